FILE: sv/ospf_packet_field_parser_macros.svh
// Assertion macros for the OSPF packet field parser.
`ifndef OSPF_PACKET_FIELD_PARSER_MACROS_SVH
`define OSPF_PACKET_FIELD_PARSER_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define OPFP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked at every rising clock edge outside reset.
`define OPFP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/opfp_pkg.sv
//------------------------------------------------------------------------------
// opfp_pkg
// Shared types and constants of the OSPF packet field parser.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package opfp_pkg;

   localparam logic [3:0] KIND_HEADER    = 4'd0;
   localparam logic [3:0] KIND_HELLO     = 4'd1;
   localparam logic [3:0] KIND_NEIGHBOR  = 4'd2;
   localparam logic [3:0] KIND_LSU_COUNT = 4'd3;
   localparam logic [3:0] KIND_LSA_HDR   = 4'd4;
   localparam logic [3:0] KIND_ROUTER    = 4'd5;
   localparam logic [3:0] KIND_LINK      = 4'd6;
   localparam logic [3:0] KIND_TOS       = 4'd7;
   localparam logic [3:0] KIND_NET_MASK  = 4'd8;
   localparam logic [3:0] KIND_ATTACHED  = 4'd9;
   localparam logic [3:0] KIND_TRUNCATED = 4'd10;

   // OSPF message types and LSA types that have a parsed body.
   localparam logic [7:0] MSG_HELLO   = 8'd1;
   localparam logic [7:0] MSG_LSU     = 8'd4;
   localparam logic [7:0] LSA_ROUTER  = 8'd1;
   localparam logic [7:0] LSA_NETWORK = 8'd2;

   localparam int unsigned QUEUE_DEPTH = 2;

   // One result record as it crosses from the parser to the output side.
   typedef struct packed {
      logic [3:0]  record_kind;
      logic [31:0] word_a;
      logic [31:0] word_b;
      logic [31:0] word_c;
      logic [15:0] half_a;
      logic [15:0] half_b;
      logic [7:0]  small_a;
      logic [7:0]  small_b;
   } record_type;

   // Handshake status between the parser and the record queue.
   typedef struct packed {
      logic push;
      logic full;
   } queue_ctl_type;

endpackage

`default_nettype wire

FILE: sv/opfp_parser.sv
//------------------------------------------------------------------------------
// opfp_parser
// Front part: walks the packet byte by byte and forms result records.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opfp_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  byte_valid,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  frame_last,
   output opfp_pkg::record_type       rec,
   output logic                       rec_valid
);

   typedef enum logic [3:0] {
      PH_HDR, PH_HELLO, PH_NEIGH, PH_LSUCNT, PH_LSAHDR, PH_RTR, PH_LINK,
      PH_TOS, PH_NETMASK, PH_ATTACH, PH_LSASKIP, PH_FRAMESKIP
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [4:0]  idx_ff, idx_in;
   logic [31:0] asm_ff, asm_in;
   logic [31:0] w1_ff, w1_in, w2_ff, w2_in;
   logic [15:0] half_ff, half_in;
   logic [7:0]  small_ff, small_in;
   logic [15:0] pkt_left_ff, pkt_left_in;
   logic [31:0] lsas_ff, lsas_in;
   logic [15:0] links_ff, links_in;
   logic [7:0]  tos_ff, tos_in;
   logic [15:0] lsa_left_ff, lsa_left_in;

   opfp_pkg::record_type rec_in;
   logic                 emit;
   logic [31:0]          lsas_dec;
   logic [15:0]          links_dec;
   logic [7:0]           tos_dec;
   logic [15:0]          lsa_len;

   always_comb begin
      phase_in    = phase_ff;
      idx_in      = idx_ff + 5'd1;
      asm_in      = {asm_ff[23:0], data_byte};
      w1_in       = w1_ff;
      w2_in       = w2_ff;
      half_in     = half_ff;
      small_in    = small_ff;
      pkt_left_in = pkt_left_ff;
      lsas_in     = lsas_ff;
      links_in    = links_ff;
      tos_in      = tos_ff;
      lsa_left_in = lsa_left_ff;
      rec_in      = '0;
      emit        = 1'b0;
      lsas_dec    = lsas_ff - 32'd1;
      links_dec   = links_ff - 16'd1;
      tos_dec     = tos_ff - 8'd1;
      lsa_len     = asm_in[15:0];
      case (phase_ff)
         PH_HDR: begin
            if (idx_ff == 5'd1) small_in = data_byte;
            else if (idx_ff == 5'd3) half_in = asm_in[15:0];
            else if (idx_ff == 5'd7) w1_in = asm_in;
            else if (idx_ff == 5'd11) w2_in = asm_in;
            else if (idx_ff >= 5'd23) begin
               emit = 1'b1;
               idx_in = '0;
               rec_in.record_kind = opfp_pkg::KIND_HEADER;
               rec_in.word_a = w1_ff;
               rec_in.word_b = w2_ff;
               rec_in.half_a = half_ff;
               rec_in.small_a = small_ff;
               if (small_ff == opfp_pkg::MSG_HELLO) begin
                  pkt_left_in = (half_ff >= 16'd24) ? half_ff - 16'd24 : '0;
                  phase_in = PH_HELLO;
               end else if (small_ff == opfp_pkg::MSG_LSU) phase_in = PH_LSUCNT;
               else phase_in = PH_FRAMESKIP;
            end
         end
         PH_HELLO, PH_NEIGH: begin
            if (pkt_left_ff != '0) pkt_left_in = pkt_left_ff - 16'd1;
            if (phase_ff == PH_HELLO && idx_ff == 5'd3) w1_in = asm_in;
            else if (phase_ff == PH_HELLO && idx_ff == 5'd15) w2_in = asm_in;
            else if ((phase_ff == PH_HELLO && idx_ff >= 5'd19) ||
                     (phase_ff == PH_NEIGH && idx_ff >= 5'd3)) begin
               emit = 1'b1;
               idx_in = '0;
               if (phase_ff == PH_HELLO) begin
                  rec_in.record_kind = opfp_pkg::KIND_HELLO;
                  rec_in.word_a = w1_ff;
                  rec_in.word_b = w2_ff;
                  rec_in.word_c = asm_in;
               end else begin
                  rec_in.record_kind = opfp_pkg::KIND_NEIGHBOR;
                  rec_in.word_a = asm_in;
               end
               phase_in = (pkt_left_in >= 16'd4) ? PH_NEIGH : PH_FRAMESKIP;
            end
         end
         PH_LSUCNT: begin
            if (idx_ff >= 5'd3) begin
               emit = 1'b1;
               idx_in = '0;
               rec_in.record_kind = opfp_pkg::KIND_LSU_COUNT;
               rec_in.word_a = asm_in;
               lsas_in = asm_in;
               phase_in = (asm_in == '0) ? PH_FRAMESKIP : PH_LSAHDR;
            end
         end
         PH_LSAHDR: begin
            if (idx_ff == 5'd3) small_in = data_byte;
            else if (idx_ff == 5'd7) w1_in = asm_in;
            else if (idx_ff == 5'd11) w2_in = asm_in;
            else if (idx_ff >= 5'd19) begin
               emit = 1'b1;
               idx_in = '0;
               half_in = lsa_len;
               rec_in.record_kind = opfp_pkg::KIND_LSA_HDR;
               rec_in.word_a = w1_ff;
               rec_in.word_b = w2_ff;
               rec_in.half_a = lsa_len;
               rec_in.small_a = small_ff;
               lsa_left_in = (lsa_len >= 16'd20) ? lsa_len - 16'd20 : '0;
               if (small_ff == opfp_pkg::LSA_ROUTER) phase_in = PH_RTR;
               else if (small_ff == opfp_pkg::LSA_NETWORK) phase_in = PH_NETMASK;
               else if (lsa_left_in != '0) phase_in = PH_LSASKIP;
               else begin
                  lsas_in = lsas_dec;
                  phase_in = (lsas_dec == '0) ? PH_FRAMESKIP : PH_LSAHDR;
               end
            end
         end
         PH_RTR: begin
            if (idx_ff >= 5'd3) begin
               emit = 1'b1;
               idx_in = '0;
               rec_in.record_kind = opfp_pkg::KIND_ROUTER;
               rec_in.half_a = asm_in[31:16];
               rec_in.half_b = asm_in[15:0];
               links_in = asm_in[15:0];
               if (asm_in[15:0] == '0) begin
                  lsas_in = lsas_dec;
                  phase_in = (lsas_dec == '0) ? PH_FRAMESKIP : PH_LSAHDR;
               end else phase_in = PH_LINK;
            end
         end
         PH_LINK, PH_TOS: begin
            if (phase_ff == PH_LINK && idx_ff == 5'd3) w1_in = asm_in;
            else if (phase_ff == PH_LINK && idx_ff == 5'd7) w2_in = asm_in;
            else if (phase_ff == PH_LINK && idx_ff == 5'd8) small_in = data_byte;
            else if (phase_ff == PH_LINK && idx_ff == 5'd9) tos_in = data_byte;
            else if (phase_ff == PH_TOS && idx_ff == 5'd0) small_in = data_byte;
            else if ((phase_ff == PH_LINK && idx_ff >= 5'd11) ||
                     (phase_ff == PH_TOS && idx_ff >= 5'd3)) begin
               emit = 1'b1;
               idx_in = '0;
               rec_in.half_a = asm_in[15:0];
               rec_in.small_a = small_ff;
               if (phase_ff == PH_LINK) begin
                  rec_in.record_kind = opfp_pkg::KIND_LINK;
                  rec_in.word_a = w1_ff;
                  rec_in.word_b = w2_ff;
                  rec_in.small_b = tos_ff;
               end else begin
                  rec_in.record_kind = opfp_pkg::KIND_TOS;
                  tos_in = tos_dec;
               end
               if (phase_ff == PH_LINK && tos_ff != '0) phase_in = PH_TOS;
               else if (phase_ff == PH_TOS && tos_dec != '0) phase_in = PH_TOS;
               else begin
                  // The link is finished: count it off and maybe the LSA too.
                  links_in = links_dec;
                  if (links_dec == '0) begin
                     lsas_in = lsas_dec;
                     phase_in = (lsas_dec == '0) ? PH_FRAMESKIP : PH_LSAHDR;
                  end else phase_in = PH_LINK;
               end
            end
         end
         PH_NETMASK, PH_ATTACH: begin
            if (lsa_left_ff != '0) lsa_left_in = lsa_left_ff - 16'd1;
            if (idx_ff >= 5'd3) begin
               emit = 1'b1;
               idx_in = '0;
               rec_in.record_kind = (phase_ff == PH_NETMASK) ?
                  opfp_pkg::KIND_NET_MASK : opfp_pkg::KIND_ATTACHED;
               rec_in.word_a = asm_in;
               if (lsa_left_in >= 16'd4) phase_in = PH_ATTACH;
               else if (lsa_left_in != '0) phase_in = PH_LSASKIP;
               else begin
                  lsas_in = lsas_dec;
                  phase_in = (lsas_dec == '0) ? PH_FRAMESKIP : PH_LSAHDR;
               end
            end
         end
         PH_LSASKIP: begin
            idx_in = '0;
            if (lsa_left_ff != '0) lsa_left_in = lsa_left_ff - 16'd1;
            if (lsa_left_in == '0) begin
               lsas_in = lsas_dec;
               phase_in = (lsas_dec == '0) ? PH_FRAMESKIP : PH_LSAHDR;
            end
         end
         default: begin
            idx_in = '0;
            phase_in = PH_FRAMESKIP;
         end
      endcase
      if (frame_last) begin
         if (!emit && phase_ff != PH_LSASKIP && phase_ff != PH_FRAMESKIP) begin
            emit = 1'b1;
            rec_in = '0;
            rec_in.record_kind = opfp_pkg::KIND_TRUNCATED;
         end
         phase_in = PH_HDR;
         idx_in = '0;
         asm_in = '0;
         w1_in = '0;
         w2_in = '0;
         half_in = '0;
         small_in = '0;
         pkt_left_in = '0;
         lsas_in = '0;
         links_in = '0;
         tos_in = '0;
         lsa_left_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR;
         idx_ff      <= '0;
         asm_ff      <= '0;
         w1_ff       <= '0;
         w2_ff       <= '0;
         half_ff     <= '0;
         small_ff    <= '0;
         pkt_left_ff <= '0;
         lsas_ff     <= '0;
         links_ff    <= '0;
         tos_ff      <= '0;
         lsa_left_ff <= '0;
      end else if (byte_valid) begin
         phase_ff    <= phase_in;
         idx_ff      <= idx_in;
         asm_ff      <= asm_in;
         w1_ff       <= w1_in;
         w2_ff       <= w2_in;
         half_ff     <= half_in;
         small_ff    <= small_in;
         pkt_left_ff <= pkt_left_in;
         lsas_ff     <= lsas_in;
         links_ff    <= links_in;
         tos_ff      <= tos_in;
         lsa_left_ff <= lsa_left_in;
      end
   end

   assign rec       = rec_in;
   assign rec_valid = byte_valid && emit;

endmodule

`default_nettype wire

FILE: sv/opfp_queue.sv
//------------------------------------------------------------------------------
// opfp_queue
// Back part: a two-entry record queue that drives the result channel.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opfp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  opfp_pkg::record_type       push_rec,
   output opfp_pkg::queue_ctl_type    ctl,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output opfp_pkg::record_type       out_rec
);

   opfp_pkg::record_type slot_ff [opfp_pkg::QUEUE_DEPTH];
   logic       rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = count_ff != 2'd0;
   assign out_rec   = slot_ff[rd_ptr_ff];
   assign ctl.push  = push;
   assign ctl.full  = count_ff == 2'(opfp_pkg::QUEUE_DEPTH);

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= push_rec;
   end

endmodule

`default_nettype wire

FILE: sv/ospf_packet_field_parser.sv
//------------------------------------------------------------------------------
// ospf_packet_field_parser
// Byte-serial OSPFv2 packet walker that emits one record per field group.
//------------------------------------------------------------------------------
// Usage: packet bytes enter on the req_ channel one per transfer, network
// order, with req_tlast high on the final byte of each packet. Each byte that
// completes a field group (header, Hello body, neighbor, LSU count, LSA header,
// router-LSA flags, link, TOS entry, network mask, attached router) produces
// one record on the rsp_ channel, its kind on rsp_tuser; a packet that ends
// inside a field group produces a truncated record. Skipped bytes produce nothing.
// A record is registered into the record queue when the byte that completes it
// is taken. Throughput: one byte per cycle while the record queue is not full.
// A two-entry record queue parts the parser from the output; the input is
// stalled only while that queue is full, so a stalled receiver holds the
// record stream without loss and input resumes as soon as a slot frees.
// Reset clears the parse state to await a new packet header and empties the
// queue; there is no clearing pass.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ospf_packet_field_parser_macros.svh"

module ospf_packet_field_parser (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] data_byte
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [31:0] word_a, [63:32] word_b, [95:64] word_c, [111:96] half_a,
   // [127:112] half_b, [135:128] small_a, [143:136] small_b
   output logic [143:0]      rsp_tdata,
   output logic [3:0]        rsp_tuser    // [3:0] record_kind
);

   opfp_pkg::record_type    rec, out_rec;
   logic                    rec_valid, accept;
   opfp_pkg::queue_ctl_type ctl;

   // A byte may only be taken when its possible record has a free slot.
   assign req_tready = !ctl.full;
   assign accept     = req_tvalid && req_tready;

   opfp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (accept),
      .data_byte  (req_tdata),
      .frame_last (req_tlast),
      .rec        (rec),
      .rec_valid  (rec_valid)
   );

   opfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_valid),
      .push_rec  (rec),
      .ctl       (ctl),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (out_rec)
   );

   assign rsp_tdata = {out_rec.small_b, out_rec.small_a, out_rec.half_b,
                       out_rec.half_a, out_rec.word_c, out_rec.word_b,
                       out_rec.word_a};
   assign rsp_tuser = out_rec.record_kind;

   `OPFP_ASSERT_IMPL(a_no_push_when_full, clock, reset, ctl.full, !ctl.push,
      "record pushed into a full queue")
   `OPFP_ASSERT_NEXT(a_push_gives_valid, clock, reset, ctl.push, rsp_tvalid,
      "pushed record not visible on output")
   `OPFP_ASSERT_IMPL(a_kind_range, clock, reset, rsp_tvalid,
      out_rec.record_kind <= opfp_pkg::KIND_TRUNCATED, "record kind out of range")

endmodule

`default_nettype wire
